// ----- rtl/qdad_pkg.sv -----
package qdad_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_FAST_THRESHOLD  = 2'd0,
        CFG_SHORT_DEBOUNCE  = 2'd1,
        CFG_LONG_DEBOUNCE   = 2'd2,
        CFG_PRESET_POSITION = 2'd3
    } cfg_index_t;

    localparam int CFG_DATA_W = 10;

    localparam logic [9:0] FAST_THRESHOLD_RST  = 10'd100;
    localparam logic [7:0] SHORT_DEBOUNCE_RST  = 8'd10;
    localparam logic [7:0] LONG_DEBOUNCE_RST   = 8'd30;
    localparam logic [7:0] PRESET_POSITION_RST = 8'd127;

    localparam logic [7:0] POSITION_MAX = 8'd255;
    localparam logic [7:0] POSITION_MIN = 8'd0;

    // Display zone codes and their bounds.
    typedef enum logic [1:0] {
        ZONE_ALERT  = 2'd0,
        ZONE_HIGH   = 2'd1,
        ZONE_NORMAL = 2'd2
    } zone_t;

    localparam logic [7:0] ZONE_LOW_LIMIT  = 8'd10;
    localparam logic [7:0] ZONE_BAND_START = 8'd50;
    localparam logic [7:0] ZONE_HIGH_START = 8'd80;

    typedef struct packed {
        logic phase_a;
        logic phase_b;
        logic preset_pressed;
    } sample_t;

    typedef struct packed {
        logic [7:0] position_out;
        logic [1:0] zone;
        logic       edge_accepted;
    } result_t;

    // Decoder state other than the tick timer.
    typedef struct packed {
        logic [7:0] position;
        logic       prev_a;
        logic       prev_b;
        logic       primed;
        logic [7:0] debounce_len;
    } dec_state_t;

    typedef struct packed {
        logic [9:0] fast_threshold;
        logic [7:0] short_debounce;
        logic [7:0] long_debounce;
        logic [7:0] preset_position;
    } cfg_t;

    function automatic logic [1:0] zone_of(input logic [7:0] v);
        logic [1:0] z;
        begin
            if (v < ZONE_LOW_LIMIT || (v > ZONE_BAND_START && v < ZONE_HIGH_START))
                z = ZONE_ALERT;
            else if (v >= ZONE_HIGH_START)
                z = ZONE_HIGH;
            else
                z = ZONE_NORMAL;
            return z;
        end
    endfunction

endpackage

// ----- rtl/quadrature_decoder_adaptive_debounce.sv -----
// Quadrature decoder (x4) with adaptive debounce and a preset button.
// Sample channel: one item per tick carries the sampled phases A and B and
// the preset button level; it is taken when sample_valid is high and
// sample_stall is low. Result channel: every sample item yields exactly one
// result item (position, display zone, edge flag) on result_valid, held
// steady while result_stall is high.
// Registered result: a sample taken at one edge shows on the result port
// right after that edge. Throughput is one item per cycle, set by the single
// pass from the state registers through the decode logic into the result
// register; sample_stall rises only while a result waits and the receiver
// stalls, so a new item is taken in the same cycle the old result leaves.
// Configuration goes through cfg_we/cfg_index/cfg_data, one register per
// cycle; the user writes it only while the block is idle, unenforced by it.
// Reset clears the position, the timer and the primed flag, loads the
// initial debounce length and the register defaults, and empties the result
// register. The first item after reset loads the phase history and takes no edge.
module quadrature_decoder_adaptive_debounce #(
    parameter int TIMER_WIDTH      = 16,
    parameter int INITIAL_DEBOUNCE = 20
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_stall,
    input  qdad_pkg::sample_t       sample,
    output logic                    result_valid,
    input  logic                    result_stall,
    output qdad_pkg::result_t       result,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [qdad_pkg::CFG_DATA_W-1:0] cfg_data
);

    qdad_pkg::cfg_t          cfg_reg;
    qdad_pkg::dec_state_t    state_reg;
    qdad_pkg::dec_state_t    state_next;
    logic [TIMER_WIDTH-1:0]  elapsed_reg;
    logic [TIMER_WIDTH-1:0]  elapsed_next;
    qdad_pkg::result_t       result_reg;
    qdad_pkg::result_t       result_next;
    logic                    result_valid_reg;
    logic                    sample_fire;

    // The result register can take a new item whenever it is empty or its
    // current item leaves in this cycle.
    assign sample_stall = result_valid_reg && result_stall;
    assign sample_fire  = sample_valid && !sample_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_threshold  <= qdad_pkg::FAST_THRESHOLD_RST;
            cfg_reg.short_debounce  <= qdad_pkg::SHORT_DEBOUNCE_RST;
            cfg_reg.long_debounce   <= qdad_pkg::LONG_DEBOUNCE_RST;
            cfg_reg.preset_position <= qdad_pkg::PRESET_POSITION_RST;
        end
        else if (cfg_we)
        begin
            case (qdad_pkg::cfg_index_t'(cfg_index))
                qdad_pkg::CFG_FAST_THRESHOLD:  cfg_reg.fast_threshold  <= cfg_data;
                qdad_pkg::CFG_SHORT_DEBOUNCE:  cfg_reg.short_debounce  <= cfg_data[7:0];
                qdad_pkg::CFG_LONG_DEBOUNCE:   cfg_reg.long_debounce   <= cfg_data[7:0];
                qdad_pkg::CFG_PRESET_POSITION: cfg_reg.preset_position <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    qdad_decode #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_decode (
        .sample       (sample),
        .cfg          (cfg_reg),
        .state        (state_reg),
        .elapsed      (elapsed_reg),
        .state_next   (state_next),
        .elapsed_next (elapsed_next),
        .result       (result_next)
    );

    // Decoder state advances once per accepted sample item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.position     <= '0;
            state_reg.prev_a       <= 1'b0;
            state_reg.prev_b       <= 1'b0;
            state_reg.primed       <= 1'b0;
            state_reg.debounce_len <= 8'(INITIAL_DEBOUNCE);
            elapsed_reg            <= '0;
        end
        else if (sample_fire)
        begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (sample_fire)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (sample_fire)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    // An accepted edge restarts the debounce timer.
    a_timer_restart: assert property (@(posedge clk) disable iff (!rst_n)
        sample_fire && result_next.edge_accepted |=> elapsed_reg == '0)
        else $error("timer not cleared after an accepted edge");

    // No edge can be accepted before the phase history is loaded.
    a_no_edge_unprimed: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.primed |-> !result_next.edge_accepted)
        else $error("edge accepted before the first sample");

    // The first accepted item primes the decoder.
    a_primed_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        sample_fire |=> state_reg.primed)
        else $error("decoder not primed after an item");

    // Input side stalls only because a result is held back.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid_reg && result_stall)
        else $error("sample channel stalled without a waiting result");
`endif

endmodule

// ----- rtl/qdad_decode.sv -----
module qdad_decode #(
    parameter int TIMER_WIDTH = 16
) (
    input  qdad_pkg::sample_t    sample,
    input  qdad_pkg::cfg_t       cfg,
    input  qdad_pkg::dec_state_t state,
    input  logic [TIMER_WIDTH-1:0] elapsed,
    output qdad_pkg::dec_state_t state_next,
    output logic [TIMER_WIDTH-1:0] elapsed_next,
    output qdad_pkg::result_t    result
);

    localparam int CMP_W = (TIMER_WIDTH > qdad_pkg::CFG_DATA_W) ?
                           TIMER_WIDTH : qdad_pkg::CFG_DATA_W;

    logic [TIMER_WIDTH-1:0] elapsed_inc;
    logic                   change_a;
    logic                   change_b;
    logic                   accept;
    logic [7:0]             pos_up;
    logic [7:0]             pos_down;
    logic [7:0]             pos_edge;
    logic [CMP_W-1:0]       interval_ext;
    logic [CMP_W-1:0]       threshold_ext;

    assign elapsed_inc = (elapsed == {TIMER_WIDTH{1'b1}}) ?
                         elapsed : elapsed + TIMER_WIDTH'(1);
    assign change_a = sample.phase_a ^ state.prev_a;
    assign change_b = sample.phase_b ^ state.prev_b;
    assign accept   = state.primed && (change_a || change_b) &&
                      (elapsed_inc > TIMER_WIDTH'(state.debounce_len));

    assign pos_up   = (state.position == qdad_pkg::POSITION_MAX) ?
                      state.position : state.position + 8'd1;
    assign pos_down = (state.position == qdad_pkg::POSITION_MIN) ?
                      state.position : state.position - 8'd1;

    assign interval_ext  = CMP_W'(elapsed_inc);
    assign threshold_ext = CMP_W'(cfg.fast_threshold);

    // x4 decoding: an A edge counts up when the phases differ afterwards,
    // a B edge counts up when they match. A double change does not move.
    always_comb
    begin
        pos_edge = state.position;
        if (change_a && !change_b)
            pos_edge = (sample.phase_a != sample.phase_b) ? pos_up : pos_down;
        else if (change_b && !change_a)
            pos_edge = (sample.phase_a == sample.phase_b) ? pos_up : pos_down;
    end

    always_comb
    begin
        state_next   = state;
        elapsed_next = elapsed_inc;
        if (!state.primed)
        begin
            state_next.prev_a = sample.phase_a;
            state_next.prev_b = sample.phase_b;
            state_next.primed = 1'b1;
        end
        else if (accept)
        begin
            state_next.position     = pos_edge;
            state_next.prev_a       = sample.phase_a;
            state_next.prev_b       = sample.phase_b;
            state_next.debounce_len = (interval_ext < threshold_ext) ?
                                      cfg.short_debounce : cfg.long_debounce;
            elapsed_next            = '0;
        end
        if (sample.preset_pressed)
            state_next.position = cfg.preset_position;

        result.position_out  = state_next.position;
        result.zone          = qdad_pkg::zone_of(state_next.position);
        result.edge_accepted = accept;
    end

endmodule

// ----- dv/quadrature_decoder_adaptive_debounce_tb.sv -----
`timescale 1ns / 1ps

module quadrature_decoder_adaptive_debounce_tb;

    localparam int TIMER_WIDTH      = 16;
    localparam int INITIAL_DEBOUNCE = 20;
    localparam int RESET_CYCLES     = 12;
    // The long hold-off on the result side. It is long enough to back up the
    // single result register and push the stall back to the sample side.
    localparam int HOLD_CYCLES      = 60;
    // The watchdog limit, many times the length of the slowest correct run.
    localparam int CYCLE_LIMIT      = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            sample_valid = 1'b0;
    logic                            sample_stall;
    qdad_pkg::sample_t               tick_in = '0;
    logic                            result_valid;
    logic                            result_stall = 1'b0;
    qdad_pkg::result_t               tick_out;
    logic                            cfg_we = 1'b0;
    logic [1:0]                      cfg_index = '0;
    logic [qdad_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    quadrature_decoder_adaptive_debounce #(
        .TIMER_WIDTH      (TIMER_WIDTH),
        .INITIAL_DEBOUNCE (INITIAL_DEBOUNCE)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (tick_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (tick_out),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Samples waiting to be offered, and the readings that the accepted
    // samples are expected to produce, oldest first.
    qdad_pkg::sample_t sample_backlog[$];
    qdad_pkg::result_t pending_readings[$];

    // Our own copy of the decoder. It starts in the reset state, and reset is
    // applied only once, so the declarations give it its starting values.
    logic [7:0]             track_pos    = '0;
    logic                   track_prev_a = 1'b0;
    logic                   track_prev_b = 1'b0;
    logic                   track_primed = 1'b0;
    logic [TIMER_WIDTH-1:0] track_ticks  = '0;
    logic [7:0]             track_dbnc   = 8'(INITIAL_DEBOUNCE);

    logic [9:0] reg_fast_thr = qdad_pkg::FAST_THRESHOLD_RST;
    logic [7:0] reg_short_db = qdad_pkg::SHORT_DEBOUNCE_RST;
    logic [7:0] reg_long_db  = qdad_pkg::LONG_DEBOUNCE_RST;
    logic [7:0] reg_preset   = qdad_pkg::PRESET_POSITION_RST;

    // Handshake bookkeeping shared by the clocked processes.
    logic took_sample = 1'b0;
    logic took_result = 1'b0;
    int   tx_idle_max = 0;
    int   rx_idle_max = 0;
    int   tx_left = 0;
    int   rx_left = 0;
    logic hold_go = 1'b0;
    logic rx_hold = 1'b0;

    // The encoder level that the stimulus generator believes it is on.
    logic gen_a = 1'b0;
    logic gen_b = 1'b0;

    int err_count   = 0;
    int n_samples   = 0;
    int n_checked   = 0;
    int n_edges     = 0;
    int n_presets   = 0;
    int n_settings  = 0;
    int cycle_count = 0;

    // One tick of the decoder: advance the saturating tick timer, take a
    // phase change as an edge only once the timer has passed the debounce
    // length, decode it x4, pick the next debounce length from the interval,
    // and let the preset button have the last word on the position.
    function automatic qdad_pkg::result_t decode_tick(input qdad_pkg::sample_t s);
        qdad_pkg::result_t      r;
        logic                   hit;
        logic                   chg_a;
        logic                   chg_b;
        logic [TIMER_WIDTH-1:0] span;
        hit = 1'b0;
        if (track_ticks != '1)
            track_ticks = track_ticks + 1'b1;
        chg_a = (s.phase_a != track_prev_a);
        chg_b = (s.phase_b != track_prev_b);
        if (!track_primed) begin
            // The first sample after reset only seeds the phase history.
            track_prev_a = s.phase_a;
            track_prev_b = s.phase_b;
            track_primed = 1'b1;
        end else if ((chg_a || chg_b) && track_ticks > track_dbnc) begin
            hit  = 1'b1;
            span = track_ticks;
            // Phase A moving to a mismatch, or phase B moving to a match,
            // is one step up. A change of both phases is not a valid
            // quadrature step and leaves the position where it is.
            if (chg_a != chg_b) begin
                if ((s.phase_a != s.phase_b) == chg_a) begin
                    if (track_pos != qdad_pkg::POSITION_MAX)
                        track_pos = track_pos + 1'b1;
                end else begin
                    if (track_pos != qdad_pkg::POSITION_MIN)
                        track_pos = track_pos - 1'b1;
                end
            end
            track_prev_a = s.phase_a;
            track_prev_b = s.phase_b;
            track_dbnc   = (span < reg_fast_thr) ? reg_short_db : reg_long_db;
            track_ticks  = '0;
        end
        if (s.preset_pressed)
            track_pos = reg_preset;
        r.position_out  = track_pos;
        r.edge_accepted = hit;
        if (track_pos < qdad_pkg::ZONE_LOW_LIMIT ||
            (track_pos > qdad_pkg::ZONE_BAND_START &&
             track_pos < qdad_pkg::ZONE_HIGH_START))
            r.zone = qdad_pkg::ZONE_ALERT;
        else if (track_pos >= qdad_pkg::ZONE_HIGH_START)
            r.zone = qdad_pkg::ZONE_HIGH;
        else
            r.zone = qdad_pkg::ZONE_NORMAL;
        return r;
    endfunction

    // Register writes and accepted samples are both taken at the rising edge,
    // exactly where the block takes them. Writes only ever happen while the
    // block is idle, so the two never meet on one edge.
    always @(posedge clk)
    begin : predictor
        took_sample <= rst_n && sample_valid && !sample_stall;
        if (rst_n && cfg_we) begin
            case (cfg_index)
                qdad_pkg::CFG_FAST_THRESHOLD:  reg_fast_thr = cfg_data[9:0];
                qdad_pkg::CFG_SHORT_DEBOUNCE:  reg_short_db = cfg_data[7:0];
                qdad_pkg::CFG_LONG_DEBOUNCE:   reg_long_db  = cfg_data[7:0];
                qdad_pkg::CFG_PRESET_POSITION: reg_preset   = cfg_data[7:0];
                default: ;
            endcase
        end
        if (rst_n && sample_valid && !sample_stall) begin
            if (tick_in.preset_pressed)
                n_presets++;
            pending_readings.push_back(decode_tick(tick_in));
            n_samples++;
        end
    end

    // Every accepted result is held against the oldest expected reading. The
    // result of a sample shows up no earlier than the edge after the sample
    // was taken, so a push and a pop on the same edge never touch one entry.
    always @(posedge clk)
    begin : monitor
        qdad_pkg::result_t want;
        took_result <= rst_n && result_valid && !result_stall;
        if (rst_n && result_valid && !result_stall) begin
            if (pending_readings.size() == 0) begin
                err_count++;
                $display("%0t: result with none expected: position %0d zone %0d edge %0b",
                         $time, tick_out.position_out, tick_out.zone,
                         tick_out.edge_accepted);
            end else begin
                want = pending_readings.pop_front();
                n_checked++;
                if (tick_out.position_out !== want.position_out) begin
                    err_count++;
                    $display("%0t: position_out mismatch: expected %0d, got %0d",
                             $time, want.position_out, tick_out.position_out);
                end
                if (tick_out.zone !== want.zone) begin
                    err_count++;
                    $display("%0t: zone mismatch: expected %0d, got %0d",
                             $time, want.zone, tick_out.zone);
                end
                if (tick_out.edge_accepted !== want.edge_accepted) begin
                    err_count++;
                    $display("%0t: edge_accepted mismatch: expected %0b, got %0b",
                             $time, want.edge_accepted, tick_out.edge_accepted);
                end
            end
            if (tick_out.edge_accepted === 1'b1)
                n_edges++;
        end
    end

    // Sender. Once the current item is taken (or nothing is on offer), it
    // either sits out the gap drawn for the last item or offers the next one
    // from the backlog. A stalled item is left exactly as it is.
    always @(negedge clk)
    begin : sender
        if (!rst_n)
            sample_valid <= 1'b0;
        else if (!sample_valid || took_sample) begin
            if (tx_left != 0) begin
                sample_valid <= 1'b0;
                tx_left      <= tx_left - 1;
            end else if (sample_backlog.size() != 0) begin
                tick_in      <= sample_backlog.pop_front();
                sample_valid <= 1'b1;
                tx_left      <= (tx_idle_max == 0) ? 0 : $urandom_range(0, tx_idle_max);
            end else begin
                sample_valid <= 1'b0;
            end
        end
    end

    // Receiver. After each result it draws how long to stall before the next
    // one; the long hold-off overrides all of that while it lasts.
    always @(negedge clk)
    begin : receiver
        int unsigned wait_n;
        if (rx_hold)
            result_stall <= 1'b1;
        else if (took_result) begin
            wait_n       = (rx_idle_max == 0) ? 0 : $urandom_range(0, rx_idle_max);
            result_stall <= (wait_n != 0);
            rx_left      <= (wait_n != 0) ? wait_n - 1 : 0;
        end else if (rx_left != 0) begin
            result_stall <= 1'b1;
            rx_left      <= rx_left - 1;
        end else begin
            result_stall <= 1'b0;
        end
    end

    // The long hold-off runs once, counted here, while the sender keeps
    // offering items with no gaps of its own.
    initial
    begin : rx_hold_off
        wait (hold_go);
        repeat (4) @(negedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d readings outstanding",
                     cycle_count, pending_readings.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input qdad_pkg::cfg_index_t idx,
                             input logic [qdad_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Loads all four registers and the idling levels for the next stretch.
    // The 8-bit registers get random junk in the unused upper data bits,
    // which the block has to drop.
    task automatic set_regs(input logic [9:0] thr, input logic [7:0] sdb,
                            input logic [7:0] ldb, input logic [7:0] pre,
                            input int tx, input int rx);
        logic [1:0] upper;
        write_reg(qdad_pkg::CFG_FAST_THRESHOLD, thr);
        upper = $urandom_range(0, 3);
        write_reg(qdad_pkg::CFG_SHORT_DEBOUNCE, {upper, sdb});
        upper = $urandom_range(0, 3);
        write_reg(qdad_pkg::CFG_LONG_DEBOUNCE, {upper, ldb});
        upper = $urandom_range(0, 3);
        write_reg(qdad_pkg::CFG_PRESET_POSITION, {upper, pre});
        tx_idle_max = tx;
        rx_idle_max = rx;
        n_settings++;
    endtask

    task automatic push_item(input logic a, input logic b, input logic p);
        qdad_pkg::sample_t v;
        v.phase_a        = a;
        v.phase_b        = b;
        v.preset_pressed = p;
        sample_backlog.push_back(v);
    endtask

    // Turns the knob: each step moves one quadrature state up or down (now
    // and then an illegal jump of both phases), may chatter between the old
    // and new level first, then holds the new level for a random dwell.
    // The preset button is pressed now and then along the way.
    task automatic rotate(input int steps, input int dwell_lo, input int dwell_hi);
        bit   up;
        int   dwell;
        int   chatter;
        logic old_a;
        logic old_b;
        up = $urandom_range(0, 1);
        repeat (steps) begin
            if ($urandom_range(0, 7) == 0)
                up = !up;
            old_a = gen_a;
            old_b = gen_b;
            if ($urandom_range(0, 11) == 0) begin
                gen_a = !gen_a;
                gen_b = !gen_b;
            end else if (up == (gen_a == gen_b))
                gen_a = !gen_a;
            else
                gen_b = !gen_b;
            chatter = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            repeat (chatter) begin
                push_item(gen_a, gen_b, $urandom_range(0, 39) == 0);
                push_item(old_a, old_b, $urandom_range(0, 39) == 0);
            end
            dwell = $urandom_range(dwell_lo, dwell_hi);
            repeat (dwell)
                push_item(gen_a, gen_b, $urandom_range(0, 39) == 0);
        end
    endtask

    // Uncorrelated pin garbage; the generator carries on from wherever the
    // last sample left the phases.
    task automatic noise(input int n);
        repeat (n) begin
            gen_a = $urandom_range(0, 1);
            gen_b = $urandom_range(0, 1);
            push_item(gen_a, gen_b, $urandom_range(0, 5) == 0);
        end
    endtask

    // Waits until every sample is taken and every reading has come back,
    // so the block is surely idle. Checked on the rising edge, where the
    // sender's signals are settled.
    task automatic drain_all();
        do
            @(posedge clk);
        while (sample_backlog.size() != 0 || sample_valid || pending_readings.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    initial
    begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening. Short debounce is zero and long is one, so the
        // edges below are accepted after one or two ticks.
        set_regs(10'd3, 8'd0, 8'd1, 8'd255, 2, 2);
        // The first sample only seeds the phases. A change that comes before
        // the initial debounce length runs out is refused until it does;
        // here it is a down count at position zero, which must stay at zero.
        push_item(1'b0, 1'b0, 1'b0);
        repeat (INITIAL_DEBOUNCE)
            push_item(1'b0, 1'b1, 1'b0);
        // Up one step: refused on the first tick, taken on the second.
        push_item(1'b0, 1'b0, 1'b0);
        push_item(1'b0, 1'b0, 1'b0);
        // The preset button loads the top value; one more step up saturates.
        push_item(1'b0, 1'b0, 1'b1);
        push_item(1'b1, 1'b0, 1'b0);
        // Both phases flip at once: accepted, but the position holds.
        push_item(1'b0, 1'b1, 1'b0);
        // A down edge and the preset on the same tick: the preset wins, the
        // edge is still flagged.
        push_item(1'b1, 1'b1, 1'b1);
        // Down from the top, then a slow step so the long length comes back.
        push_item(1'b1, 1'b0, 1'b0);
        repeat (3)
            push_item(1'b1, 1'b0, 1'b0);
        push_item(1'b0, 1'b0, 1'b0);
        push_item(1'b0, 1'b1, 1'b0);
        push_item(1'b0, 1'b1, 1'b0);
        gen_a = 1'b0;
        gen_b = 1'b1;
        drain_all();

        // Dwell straddles the fast threshold, so both lengths take turns.
        // The preset sits just above the lower edge of the alert band.
        set_regs(10'd5, 8'd1, 8'd3, 8'd52, 4, 4);
        rotate(20, 1, 8);
        noise(10);
        rotate(6, 1, 8);
        drain_all();

        // Everything at zero: every change is taken on the next tick and all
        // rotation counts as slow. Neither side idles in this stretch.
        set_regs(10'd0, 8'd0, 8'd0, 8'd0, 0, 0);
        rotate(25, 1, 3);
        noise(10);
        drain_all();

        // The result side holds off for a long stretch while the sample side
        // keeps pushing, so the block has to stall its input.
        set_regs(10'd1023, 8'd2, 8'd7, 8'd255, 0, 2);
        rotate(25, 1, 4);
        hold_go = 1'b1;
        drain_all();

        // Longest debounce lengths: one ordinary edge makes the next one wait
        // past the top of the range, and that slow edge must still get in.
        set_regs(10'd1023, 8'd255, 8'd255, 8'($urandom_range(0, 255)), 1, 3);
        rotate(1, 10, 10);
        rotate(1, 258, 258);
        drain_all();

        // Random small settings around the upper edge of the alert band. The
        // first step has to outlast the long length left over from above.
        set_regs(10'($urandom_range(3, 12)), 8'($urandom_range(0, 3)),
                 8'($urandom_range(2, 9)), 8'd79, 2, 4);
        rotate(1, 258, 258);
        rotate(10, 1, 10);
        noise(12);
        rotate(3, 1, 10);
        drain_all();

        if (pending_readings.size() != 0) begin
            err_count++;
            $display("%0t: %0d expected readings never arrived",
                     $time, pending_readings.size());
        end
        $display("Covered %0d samples and %0d checked readings over %0d register settings,",
                 n_samples, n_checked, n_settings);
        $display("with %0d debounced edges and %0d preset loads; %0d mismatches.",
                 n_edges, n_presets, err_count);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/qdad_pkg.sv
rtl/qdad_decode.sv
rtl/quadrature_decoder_adaptive_debounce.sv
dv/quadrature_decoder_adaptive_debounce_tb.sv
